[hdl/ipap_pkg.sv]
// Package of the IPv4 address pool allocator.
// Holds shared types, codes and constants; it depends on nothing.
package ipap_pkg;

  localparam int ADDR_W   = 32;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int REM_W    = BIT_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] NET_ADDRESS_RST = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] NET_MASK_RST    = 32'hFFFF_FF00;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NET_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NET_MASK    = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_ALLOC_ADDR,
    ST_REL_SUB,
    ST_REL_RD,
    ST_REL_WR,
    ST_RESULT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  idx;
    logic [WORD_W-1:0] onehot;
  } scan_res_t;

endpackage

[hdl/ip_address_pool_allocator.sv]
// Top level of the IPv4 address pool allocator: sequencer, registers and map RAM.
// Depends on ipap_pkg, ipap_ram, ipap_alu and ipap_scan.
//
//   Port group   Direction  Handshake        Word
//   in_*         input      valid / stall    func, release_address
//   out_*        output     valid / stall    host_address, ok
//   cfg_*        input      valid / ready    index, data
//
// An allocate reads and checks the 32-bit map words in turn up to a free bit and
// then forms the address in ST_ALLOC_ADDR. A full pool reports its failure once
// the last word is checked; an empty pool goes straight to ST_RESULT. A release
// passes ST_REL_SUB, ST_REL_RD and ST_REL_WR, or only ST_REL_SUB when the address
// is out of range. A new word is taken once the previous result is queued. After
// reset the map is cleared, one RAM word per cycle; input words stall meanwhile.
module ip_address_pool_allocator #(
  parameter int POOL_SIZE = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [ipap_pkg::ADDR_W-1:0]        in_release_address,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ipap_pkg::ADDR_W-1:0]        out_host_address,
  output logic                               out_ok,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ipap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipap_pkg::ADDR_W-1:0]        cfg_data
);

  localparam int DEPTH = (POOL_SIZE + ipap_pkg::WORD_W - 1) / ipap_pkg::WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int PW    = AW + ipap_pkg::BIT_W + 1;

  ipap_pkg::state_t state_r, state_nxt;

  logic [ipap_pkg::ADDR_W-1:0] net_address_r, net_mask_r;
  logic [ipap_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [ipap_pkg::ADDR_W-1:0] span;

  logic [ipap_pkg::ADDR_W-1:0] rel_r, rel_nxt;
  logic [AW-1:0]               word_r, word_nxt;
  logic [ipap_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic [ipap_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic                        res_ok_r, res_ok_nxt;

  logic                        out_valid_r;
  logic [ipap_pkg::ADDR_W-1:0] out_addr_r;
  logic                        out_ok_r;
  logic                        out_free;
  logic                        in_acc;

  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [ipap_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  ipap_pkg::alu_op_t           alu_op;
  logic [ipap_pkg::ADDR_W-1:0] alu_a, alu_b, alu_res;
  logic                        alu_lt;

  logic [PW-1:0]               rem_w;
  logic [ipap_pkg::REM_W-1:0]  rem6;
  logic                        last_word;
  ipap_pkg::scan_res_t         scan;

  ipap_ram #(
    .WIDTH(ipap_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  ipap_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .lim(ipap_pkg::ADDR_W'(count_r)),
    .res(alu_res),
    .lt (alu_lt)
  );

  ipap_scan u_scan (
    .data(ram_rdata),
    .rem (rem6),
    .res (scan)
  );

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_host_address = out_addr_r;
  assign out_ok           = out_ok_r;
  assign out_free         = !out_valid_r || !out_stall;
  assign in_acc           = in_valid && !in_stall;

  always_comb begin
    span     = ~net_mask_r;
    base_nxt = (net_address_r & net_mask_r) + ipap_pkg::ADDR_W'(1);
    if (span < ipap_pkg::ADDR_W'(2)) begin
      count_nxt = '0;
    end else if ((span - ipap_pkg::ADDR_W'(1)) > ipap_pkg::ADDR_W'(POOL_SIZE)) begin
      count_nxt = CNT_W'(POOL_SIZE);
    end else begin
      count_nxt = CNT_W'(span - ipap_pkg::ADDR_W'(1));
    end
  end

  always_comb begin
    rem_w     = PW'(count_r) - PW'({word_r, ipap_pkg::BIT_W'(0)});
    last_word = (rem_w <= PW'(ipap_pkg::WORD_W)) || (word_r == AW'(DEPTH - 1));
    if (rem_w >= PW'(ipap_pkg::WORD_W)) begin
      rem6 = ipap_pkg::REM_W'(ipap_pkg::WORD_W);
    end else begin
      rem6 = rem_w[ipap_pkg::REM_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipap_pkg::ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ipap_pkg::ST_IDLE;
        end
      end
      ipap_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func == ipap_pkg::FUNC_RELEASE) begin
            state_nxt = ipap_pkg::ST_REL_SUB;
          end else if (count_nxt == '0) begin
            state_nxt = ipap_pkg::ST_RESULT;
          end else begin
            state_nxt = ipap_pkg::ST_ALLOC_RD;
          end
        end
      end
      ipap_pkg::ST_ALLOC_RD: state_nxt = ipap_pkg::ST_ALLOC_CHK;
      ipap_pkg::ST_ALLOC_CHK: begin
        if (scan.found) begin
          state_nxt = ipap_pkg::ST_ALLOC_ADDR;
        end else if (last_word) begin
          state_nxt = ipap_pkg::ST_RESULT;
        end else begin
          state_nxt = ipap_pkg::ST_ALLOC_RD;
        end
      end
      ipap_pkg::ST_ALLOC_ADDR: state_nxt = ipap_pkg::ST_RESULT;
      ipap_pkg::ST_REL_SUB: begin
        if (alu_lt) begin
          state_nxt = ipap_pkg::ST_REL_RD;
        end else begin
          state_nxt = ipap_pkg::ST_RESULT;
        end
      end
      ipap_pkg::ST_REL_RD: state_nxt = ipap_pkg::ST_REL_WR;
      ipap_pkg::ST_REL_WR: state_nxt = ipap_pkg::ST_RESULT;
      ipap_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = ipap_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ipap_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    ram_we       = 1'b0;
    ram_addr     = word_r;
    ram_wdata    = ram_rdata;
    alu_op       = ipap_pkg::ALU_ADD;
    alu_a        = base_r;
    alu_b        = ipap_pkg::ADDR_W'({word_r, bit_r});
    rel_nxt      = rel_r;
    word_nxt     = word_r;
    bit_nxt      = bit_r;
    clr_nxt      = clr_r;
    res_addr_nxt = res_addr_r;
    res_ok_nxt   = res_ok_r;
    unique case (state_r)
      ipap_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      ipap_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        rel_nxt      = in_release_address;
        word_nxt     = '0;
        res_addr_nxt = '0;
        res_ok_nxt   = 1'b0;
      end
      ipap_pkg::ST_ALLOC_RD: begin
        ram_addr = word_r;
      end
      ipap_pkg::ST_ALLOC_CHK: begin
        if (scan.found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | scan.onehot;
          bit_nxt   = scan.idx;
        end else if (!last_word) begin
          word_nxt = word_r + AW'(1);
        end
      end
      ipap_pkg::ST_ALLOC_ADDR: begin
        alu_op       = ipap_pkg::ALU_ADD;
        alu_a        = base_r;
        alu_b        = ipap_pkg::ADDR_W'({word_r, bit_r});
        res_addr_nxt = alu_res;
        res_ok_nxt   = 1'b1;
      end
      ipap_pkg::ST_REL_SUB: begin
        alu_op   = ipap_pkg::ALU_SUB;
        alu_a    = rel_r;
        alu_b    = base_r;
        word_nxt = alu_res[ipap_pkg::BIT_W +: AW];
        bit_nxt  = alu_res[ipap_pkg::BIT_W-1:0];
      end
      ipap_pkg::ST_REL_RD: begin
        ram_addr = word_r;
      end
      ipap_pkg::ST_REL_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata & ~(ipap_pkg::WORD_W'(1) << bit_r);
        res_ok_nxt = 1'b1;
      end
      ipap_pkg::ST_RESULT: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ipap_pkg::ST_CLEAR;
      clr_r         <= '0;
      net_address_r <= ipap_pkg::NET_ADDRESS_RST;
      net_mask_r    <= ipap_pkg::NET_MASK_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ipap_pkg::REG_NET_ADDRESS: net_address_r <= cfg_data;
          ipap_pkg::REG_NET_MASK:    net_mask_r    <= cfg_data;
          default:                   net_mask_r    <= net_mask_r;
        endcase
      end
      if (state_r == ipap_pkg::ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    count_r    <= count_nxt;
    rel_r      <= rel_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    if (state_r == ipap_pkg::ST_RESULT && out_free) begin
      out_addr_r <= res_addr_r;
      out_ok_r   <= res_ok_r;
    end
  end

endmodule

[hdl/ipap_ram.sv]
// Generic single-port RAM with registered read data.
// Stand-alone; depends on no package.
module ipap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/ipap_alu.sv]
// Shared 32-bit add/subtract unit with a less-than compare on its result.
// Depends on ipap_pkg.
module ipap_alu (
  input  ipap_pkg::alu_op_t              op,
  input  logic [ipap_pkg::ADDR_W-1:0]    a,
  input  logic [ipap_pkg::ADDR_W-1:0]    b,
  input  logic [ipap_pkg::ADDR_W-1:0]    lim,
  output logic [ipap_pkg::ADDR_W-1:0]    res,
  output logic                           lt
);

  always_comb begin
    unique case (op)
      ipap_pkg::ALU_ADD: res = a + b;
      ipap_pkg::ALU_SUB: res = a - b;
      default:           res = a + b;
    endcase
    lt = (res < lim);
  end

endmodule

[hdl/ipap_scan.sv]
// Find-first-free search over one occupancy word, limited to its valid low bits.
// Depends on ipap_pkg.
module ipap_scan (
  input  logic [ipap_pkg::WORD_W-1:0] data,
  input  logic [ipap_pkg::REM_W-1:0]  rem,
  output ipap_pkg::scan_res_t         res
);

  logic [ipap_pkg::WORD_W-1:0] valid;
  logic [ipap_pkg::WORD_W-1:0] wm;
  logic [ipap_pkg::WORD_W-1:0] low;
  logic [ipap_pkg::BIT_W-1:0]  idx;

  always_comb begin
    if (rem[ipap_pkg::REM_W-1]) begin
      valid = '1;
    end else begin
      valid = (ipap_pkg::WORD_W'(1) << rem[ipap_pkg::BIT_W-1:0]) - ipap_pkg::WORD_W'(1);
    end
    wm  = data | ~valid;
    low = ~wm & (wm + ipap_pkg::WORD_W'(1));
    for (int k = 0; k < ipap_pkg::BIT_W; k++) begin
      idx[k] = 1'b0;
      for (int j = 0; j < ipap_pkg::WORD_W; j++) begin
        if (((j >> k) & 1) == 1) begin
          idx[k] = idx[k] | low[j];
        end
      end
    end
    res.found  = |low;
    res.idx    = idx;
    res.onehot = low;
  end

endmodule
